### src/jos_pkg.sv
// shared constants and types for the josephus elimination order block
package jos_pkg;

    localparam int MAX_PEOPLE = 64;
    localparam int IDX_W      = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
    localparam int COUNT_W    = $clog2(MAX_PEOPLE + 1);
    localparam int RING_W     = 7;
    localparam int STEP_W     = 12;
    localparam int PERSON_W   = 7;

    // control broadcast to every cell of the ring
    typedef struct packed {
        logic load;   // take the initial person number
        logic shift;  // move one place toward the head
        logic wrap;   // the tail cell takes the head instead of its neighbor
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

endpackage

### src/jos_cell.sv
// one place of the rotating ring of living people
module jos_cell (
    input  logic                            clk,
    input  jos_pkg::cell_ctrl_t             ctrl,
    input  logic                            is_tail,
    input  logic [jos_pkg::PERSON_W-1:0]    load_value,
    input  logic [jos_pkg::PERSON_W-1:0]    right_value,
    input  logic [jos_pkg::PERSON_W-1:0]    head_value,
    output logic [jos_pkg::PERSON_W-1:0]    value
);
    import jos_pkg::*;

    logic [PERSON_W-1:0] value_reg;
    logic [PERSON_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = load_value;
        end
        else if (ctrl.shift)
        begin
            value_next = (ctrl.wrap && is_tail) ? head_value : right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### src/josephus_elimination_order.sv
// top level: josephus elimination order over a rotating chain of person cells
//
//   channel | signals                          | word
//   --------+----------------------------------+-------------------------------
//   in      | in_valid in_ready                | ring_size, step_count
//   out     | out_valid out_ready              | person, is_survivor
//
// a run loads the ring, then every removal makes m-1 rotations of the chain
//   and one removal; the step counter against the chain sets this
// one run at a time: in_ready is high only between runs
// a removal waits while the output register holds a word not yet taken
// reset clears the state machine and the output valid; cells need no reset
module josephus_elimination_order (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [jos_pkg::RING_W-1:0]      ring_size,
    input  logic [jos_pkg::STEP_W-1:0]      step_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [jos_pkg::PERSON_W-1:0]    person,
    output logic                            is_survivor
);
    import jos_pkg::*;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   live_reg, live_next;     // living people in the chain
    logic [STEP_W-1:0]    step_reg, step_next;     // step count, zero taken as one
    logic [STEP_W-1:0]    cnt_reg, cnt_next;       // count of the person at the head
    logic                 out_valid_reg, out_valid_next;
    logic [PERSON_W-1:0]  person_reg, person_next;
    logic                 survivor_reg, survivor_next;

    cell_ctrl_t           ctrl;
    logic [PERSON_W-1:0]  cell_value [MAX_PEOPLE];
    logic [IDX_W-1:0]     tail_idx;
    logic [COUNT_W-1:0]   ring_n;
    logic                 out_free;
    logic                 in_take;

    // clamp the ring size into 1..MAX_PEOPLE
    always_comb
    begin
        if (ring_size == '0)
        begin
            ring_n = COUNT_W'(1);
        end
        else if (ring_size > RING_W'(MAX_PEOPLE))
        begin
            ring_n = COUNT_W'(MAX_PEOPLE);
        end
        else
        begin
            ring_n = COUNT_W'(ring_size);
        end
    end

    assign tail_idx = IDX_W'(live_reg - COUNT_W'(1));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        live_next      = live_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        person_next    = person_reg;
        survivor_next  = survivor_reg;
        ctrl           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    ctrl.load  = 1'b1;
                    live_next  = ring_n;
                    step_next  = (step_count == '0) ? STEP_W'(1) : step_count;
                    cnt_next   = STEP_W'(1);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (live_reg == COUNT_W'(1))
                begin
                    // lone person left at the head is the survivor
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        person_next    = cell_value[0];
                        survivor_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (cnt_reg == step_reg)
                begin
                    // remove the head, the chain closes up behind it
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        person_next    = cell_value[0];
                        survivor_next  = 1'b0;
                        ctrl.shift     = 1'b1;
                        live_next      = live_reg - COUNT_W'(1);
                        cnt_next       = STEP_W'(1);
                    end
                end
                else
                begin
                    // head moves to the tail, next person counted
                    ctrl.shift = 1'b1;
                    ctrl.wrap  = 1'b1;
                    cnt_next   = cnt_reg + STEP_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // chain of cells, cell 0 is the head
    for (genvar i = 0; i < MAX_PEOPLE; i++)
    begin : g_cell
        logic [PERSON_W-1:0] right_value;

        if (i == MAX_PEOPLE - 1)
        begin : g_end
            assign right_value = '0;
        end
        else
        begin : g_mid
            assign right_value = cell_value[i + 1];
        end

        jos_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .is_tail     (tail_idx == IDX_W'(i)),
            .load_value  (PERSON_W'(i + 1)),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .value       (cell_value[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        person_reg   <= person_next;
        survivor_reg <= survivor_next;
    end

    assign out_valid   = out_valid_reg;
    assign person      = person_reg;
    assign is_survivor = survivor_reg;

endmodule

### tb/sv/josephus_elimination_order_test.sv
// self-checking testbench for the josephus elimination order block
module josephus_elimination_order_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jos_pkg::*;

    // one output word: removed person, or survivor when flagged
    typedef struct packed {
        logic [PERSON_W-1:0] person;
        logic                is_survivor;
    } removal_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [RING_W-1:0]   ring_size = '0;
    logic [STEP_W-1:0]   step_count = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [PERSON_W-1:0] person;
    logic                is_survivor;

    // words still owed by the block, oldest first
    removal_t pending_removals [$];

    int failures = 0;
    int rings_sent = 0;
    int words_checked = 0;

    // idling control: steady_flow turns off random gaps on both sides,
    // hold_request asks the receiver to stall for that many cycles
    bit steady_flow = 1'b0;
    int hold_request = 0;
    int hold_left = 0;

    josephus_elimination_order DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ring_size   (ring_size),
        .step_count  (step_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .person      (person),
        .is_survivor (is_survivor)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #100_000_000;
        $display("josephus_elimination_order verification failed");
        $finish;
    end

    // builds the ring as a successor table and walks it exactly as the
    // block should; a step count of zero walks like a step count of one,
    // ring size zero is a lone survivor, oversize rings saturate
    function automatic void predict_josephus_order(input logic [RING_W-1:0] rs,
                                                   input logic [STEP_W-1:0] sc);
        logic [IDX_W-1:0] succ [MAX_PEOPLE];
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] prev;
        int               n;
        removal_t         w;
        n = (rs == 0) ? 1 : ((rs > MAX_PEOPLE) ? MAX_PEOPLE : int'(rs));
        for (int i = 0; i < n; i++)
            succ[i] = (i + 1 < n) ? IDX_W'(i + 1) : '0;
        cur  = '0;
        prev = IDX_W'(n - 1);
        for (int k = 1; k < n; k++)
        begin
            // count m-1 places on, the person under the count leaves
            for (int c = 1; c < int'(sc); c++)
            begin
                prev = cur;
                cur  = succ[cur];
            end
            w.person      = {1'b0, cur} + 1'b1;
            w.is_survivor = 1'b0;
            pending_removals.push_back(w);
            // unlink, counting resumes at the next living person
            succ[prev] = succ[cur];
            cur        = succ[cur];
        end
        w.person      = {1'b0, cur} + 1'b1;
        w.is_survivor = 1'b1;
        pending_removals.push_back(w);
    endfunction

    // receiver: random stalls, long hold-offs on request, counted here
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady_flow || ($urandom_range(0, 99) >= 18);
    end

    // checker: every word taken is compared with the oldest expectation
    always @(posedge clk)
    begin
        removal_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (pending_removals.size() == 0)
            begin
                $error("unexpected word: person %0d is_survivor %0b", person, is_survivor);
                failures++;
            end
            else
            begin
                want = pending_removals.pop_front();
                if (person !== want.person)
                begin
                    $error("person: expected %0d, got %0d", want.person, person);
                    failures++;
                end
                if (is_survivor !== want.is_survivor)
                begin
                    $error("is_survivor: expected %0b, got %0b",
                           want.is_survivor, is_survivor);
                    failures++;
                end
            end
        end
    end

    // offers one ring, with random idle cycles first unless flow is steady;
    // valid drops on a falling edge once the word is taken, and the task
    // returns without waiting for the run to end
    task automatic send_ring(input int unsigned rs, input int unsigned sc);
        int gap;
        gap = 0;
        if (!steady_flow)
            while ($urandom_range(0, 99) < 18)
                gap++;
        repeat (gap) @(negedge clk);
        in_valid   <= 1'b1;
        ring_size  <= RING_W'(rs);
        step_count <= STEP_W'(sc);
        do
            @(posedge clk);
        while (!in_ready);
        predict_josephus_order(RING_W'(rs), STEP_W'(sc));
        rings_sent++;
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_steady(input bit on);
        @(posedge clk);
        steady_flow = on;
        @(negedge clk);
    endtask

    // degenerate and saturated ring sizes, with mostly small steps
    task automatic test_ring_extremes();
        send_ring(0, 7);      // zero ring acts as a lone survivor
        send_ring(1, 1);
        send_ring(1, 4095);
        send_ring(2, 1);
        send_ring(2, 2);
        send_ring(64, 1);     // plain order 1..63, 64 survives
        send_ring(127, 3);    // oversize ring saturates
        send_ring(65, 2);
        send_ring(100, 0);    // zero step walks like step one
        send_ring(5, 0);
    endtask

    // long counts that lap the ring many times
    task automatic test_step_extremes();
        send_ring(64, 4095);  // slowest possible run
        send_ring(3, 4095);
        send_ring(7, 2048);
        send_ring(10, 1365);
    endtask

    // well-known instances
    task automatic test_classic_rings();
        send_ring(7, 3);
        send_ring(41, 3);
        send_ring(10, 2);
    endtask

    // receiver stalls for a long stretch while the sender keeps offering,
    // so the output register fills and in_ready stays low
    task automatic test_output_backpressure();
        @(posedge clk);
        hold_request = 400;
        @(negedge clk);
        send_ring(8, 3);
        send_ring(12, 5);
        send_ring(6, 1);
        send_ring(9, 4);
    endtask

    // mostly small rings and steps, a few wide ring sizes and very long
    // steps on tiny rings so every field bit toggles; middle stretch runs
    // with no idling on either side
    task automatic test_random_rings();
        int unsigned rs;
        int unsigned sc;
        for (int i = 0; i < 119; i++)
        begin
            if (i == 50)
                set_steady(1'b1);
            if (i == 90)
                set_steady(1'b0);
            case ($urandom_range(0, 15))
                0:
                begin
                    rs = $urandom_range(0, 127);
                    sc = $urandom_range(0, 15);
                end
                1:
                begin
                    rs = $urandom_range(1, 4);
                    sc = $urandom_range(0, 4095);
                end
                default:
                begin
                    rs = $urandom_range(1, 20);
                    sc = $urandom_range(0, 40);
                end
            endcase
            send_ring(rs, sc);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_ring_extremes();
        test_step_extremes();
        test_classic_rings();
        test_output_backpressure();
        test_random_rings();
        in_valid <= 1'b0;

        // drain, then give the block time to show any stray word
        wait (pending_removals.size() == 0);
        repeat (100) @(posedge clk);
        if (pending_removals.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_removals.size());
            failures++;
        end

        $display("covered %0d rings (empty, oversize, zero and maximal steps, classic cases,",
                 rings_sent);
        $display("random mix under stalls and a long hold-off): %0d words compared",
                 words_checked);
        if (failures == 0)
            $display("josephus_elimination_order verification clean");
        else
            $display("josephus_elimination_order verification failed");
        $finish;
    end

endmodule

### sim.f
src/jos_pkg.sv
src/jos_cell.sv
src/josephus_elimination_order.sv
tb/sv/josephus_elimination_order_test.sv
